// ===== design/sdcs_pkg.sv =====
package sdcs_pkg;

    typedef logic [2:0] t_state;

    localparam t_state S_LOAD  = 3'd0;
    localparam t_state S_START = 3'd1;
    localparam t_state S_PRIME = 3'd2;
    localparam t_state S_MERGE = 3'd3;
    localparam t_state S_EMIT  = 3'd4;

    typedef struct packed {
        logic we0;
        logic we1;
    } t_ram_ctl;

endpackage

// ===== design/sdcs_ram.sv =====
module sdcs_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/sdcs_ctrl.sv =====
module sdcs_ctrl #(
    parameter int MAX_ENTRIES = 64,
    parameter int COUNT_BITS  = 16,
    parameter int TAG_BITS    = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [COUNT_BITS-1:0]                 i_entry_count,
    input  logic [TAG_BITS-1:0]                   i_entry_tag,
    input  logic                                  i_last,
    output logic                                  o_stall,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [COUNT_BITS-1:0]                 o_sorted_count,
    output logic [TAG_BITS-1:0]                   o_sorted_tag,
    output logic                                  o_final_res,
    output logic                                  o_dropped,
    output sdcs_pkg::t_ram_ctl                    o_ram_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0]        o_waddr,
    output logic [COUNT_BITS+TAG_BITS-1:0]        o_wdata,
    output logic [$clog2(MAX_ENTRIES)-1:0]        o_raddr_a,
    output logic [$clog2(MAX_ENTRIES)-1:0]        o_raddr_b,
    input  logic [COUNT_BITS+TAG_BITS-1:0]        i_q0a,
    input  logic [COUNT_BITS+TAG_BITS-1:0]        i_q0b,
    input  logic [COUNT_BITS+TAG_BITS-1:0]        i_q1a,
    input  logic [COUNT_BITS+TAG_BITS-1:0]        i_q1b
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = CNT_W + 2;
    localparam int ENT_W  = COUNT_BITS + TAG_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    sdcs_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_ovf, n_ovf;
    logic             r_sel, n_sel;
    logic [CNT_W-1:0] r_w, n_w;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_a, n_a;
    logic [CNT_W-1:0] r_b, n_b;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_ov, n_ov;
    logic [COUNT_BITS-1:0] r_out_cnt, n_out_cnt;
    logic [TAG_BITS-1:0]   r_out_tag, n_out_tag;
    logic             r_out_fin, n_out_fin;
    logic             r_out_drop, n_out_drop;

    logic [ENT_W-1:0] s_qa, s_qb, s_pick;
    logic [SUM_W-1:0] s_n_wide, s_mid_raw, s_hi_raw, s_nb_raw, s_w2;
    logic [CNT_W-1:0] s_mid, s_hi, s_nb;
    logic             s_a_ok, s_b_ok, s_take_a;
    sdcs_pkg::t_ram_ctl s_ram;

    assign s_qa = r_sel ? i_q1a : i_q0a;
    assign s_qb = r_sel ? i_q1b : i_q0b;

    assign s_n_wide  = SUM_W'(r_n);
    assign s_mid_raw = SUM_W'(r_lo) + SUM_W'(r_w);
    assign s_hi_raw  = SUM_W'(r_lo) + (SUM_W'(r_w) << 1);
    assign s_mid     = (s_mid_raw > s_n_wide) ? r_n : s_mid_raw[CNT_W-1:0];
    assign s_hi      = (s_hi_raw > s_n_wide) ? r_n : s_hi_raw[CNT_W-1:0];
    assign s_nb_raw  = SUM_W'(s_hi) + SUM_W'(r_w);
    assign s_nb      = (s_nb_raw > s_n_wide) ? r_n : s_nb_raw[CNT_W-1:0];
    assign s_w2      = SUM_W'(r_w) << 1;

    assign s_a_ok   = r_a < s_mid;
    assign s_b_ok   = r_b < s_hi;
    assign s_take_a = s_a_ok
                      && (!s_b_ok || (s_qa[ENT_W-1:TAG_BITS] >= s_qb[ENT_W-1:TAG_BITS]));
    assign s_pick   = s_take_a ? s_qa : s_qb;

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_ovf      = r_ovf;
        n_sel      = r_sel;
        n_w        = r_w;
        n_lo       = r_lo;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        n_ov       = r_ov;
        n_out_cnt  = r_out_cnt;
        n_out_tag  = r_out_tag;
        n_out_fin  = r_out_fin;
        n_out_drop = r_out_drop;
        s_ram      = '0;
        o_waddr    = r_n[ADDR_W-1:0];
        o_wdata    = {i_entry_count, i_entry_tag};

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            sdcs_pkg::S_LOAD: begin
                if (i_valid) begin
                    if (r_n < MAX_CNT) begin
                        s_ram.we0 = 1'b1;
                        n_n       = r_n + ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_state = sdcs_pkg::S_START;
                    end
                end
            end
            sdcs_pkg::S_START: begin
                n_a   = '0;
                n_sel = 1'b0;
                if (r_n > ONE) begin
                    n_b     = ONE;
                    n_k     = '0;
                    n_lo    = '0;
                    n_w     = ONE;
                    n_state = sdcs_pkg::S_MERGE;
                end else begin
                    n_state = sdcs_pkg::S_EMIT;
                end
            end
            sdcs_pkg::S_PRIME: begin
                n_state = sdcs_pkg::S_MERGE;
            end
            sdcs_pkg::S_MERGE: begin
                s_ram.we0 = r_sel;
                s_ram.we1 = !r_sel;
                o_waddr   = r_k[ADDR_W-1:0];
                o_wdata   = s_pick;
                n_a       = r_a + {{(CNT_W-1){1'b0}}, s_take_a};
                n_b       = r_b + {{(CNT_W-1){1'b0}}, !s_take_a};
                n_k       = r_k + ONE;
                if (r_k + ONE == s_hi) begin
                    if (s_hi == r_n) begin
                        n_sel = !r_sel;
                        n_lo  = '0;
                        n_a   = '0;
                        n_k   = '0;
                        if (s_w2 >= s_n_wide) begin
                            n_state = sdcs_pkg::S_EMIT;
                        end else begin
                            n_w     = s_w2[CNT_W-1:0];
                            n_b     = s_w2[CNT_W-1:0];
                            n_state = sdcs_pkg::S_PRIME;
                        end
                    end else begin
                        n_lo = s_hi;
                        n_a  = s_hi;
                        n_b  = s_nb;
                    end
                end
            end
            sdcs_pkg::S_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_ov       = 1'b1;
                    n_out_cnt  = s_qa[ENT_W-1:TAG_BITS];
                    n_out_tag  = s_qa[TAG_BITS-1:0];
                    n_out_fin  = (r_a + ONE == r_n);
                    n_out_drop = r_ovf;
                    n_a        = r_a + ONE;
                    if (r_a + ONE == r_n) begin
                        n_n     = '0;
                        n_ovf   = 1'b0;
                        n_state = sdcs_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = sdcs_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdcs_pkg::S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_sel   <= 1'b0;
            r_w     <= '0;
            r_lo    <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
            r_sel   <= n_sel;
            r_w     <= n_w;
            r_lo    <= n_lo;
            r_a     <= n_a;
            r_b     <= n_b;
            r_k     <= n_k;
            r_ov    <= n_ov;
        end
        r_out_cnt  <= n_out_cnt;
        r_out_tag  <= n_out_tag;
        r_out_fin  <= n_out_fin;
        r_out_drop <= n_out_drop;
    end

    assign o_ram_ctl      = s_ram;
    assign o_raddr_a      = n_a[ADDR_W-1:0];
    assign o_raddr_b      = n_b[ADDR_W-1:0];
    assign o_stall        = (r_state != sdcs_pkg::S_LOAD);
    assign o_valid        = r_ov;
    assign o_sorted_count = r_out_cnt;
    assign o_sorted_tag   = r_out_tag;
    assign o_final_res    = r_out_fin;
    assign o_dropped      = r_out_drop;

endmodule

// ===== design/stable_descending_count_sort_top.sv =====
// Loading accepts one entry per cycle while o_stall is low; the transfer marked last
// closes the set of n entries. Sorting goes through a set-up state and then ceil(log2(n))
// merge passes over the n entries, with a priming state between passes; one comparator
// and two dual-read RAMs do the merging. Results then leave one per cycle while the
// output is not stalled.
// Reset is synchronous and active low; it clears the control state, not the RAMs.
module stable_descending_count_sort_top #(
    parameter int MAX_ENTRIES = 64,
    parameter int COUNT_BITS  = 16,
    parameter int TAG_BITS    = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COUNT_BITS-1:0] i_entry_count,
    input  logic [TAG_BITS-1:0]   i_entry_tag,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COUNT_BITS-1:0] o_sorted_count,
    output logic [TAG_BITS-1:0]   o_sorted_tag,
    output logic                  o_final_res,
    output logic                  o_dropped
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int ENT_W  = COUNT_BITS + TAG_BITS;

    sdcs_pkg::t_ram_ctl s_ram_ctl;
    logic [ADDR_W-1:0]  s_waddr, s_raddr_a, s_raddr_b;
    logic [ENT_W-1:0]   s_wdata, s_q0a, s_q0b, s_q1a, s_q1b;

    sdcs_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_entry_count  (i_entry_count),
        .i_entry_tag    (i_entry_tag),
        .i_last         (i_last),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_count (o_sorted_count),
        .o_sorted_tag   (o_sorted_tag),
        .o_final_res    (o_final_res),
        .o_dropped      (o_dropped),
        .o_ram_ctl      (s_ram_ctl),
        .o_waddr        (s_waddr),
        .o_wdata        (s_wdata),
        .o_raddr_a      (s_raddr_a),
        .o_raddr_b      (s_raddr_b),
        .i_q0a          (s_q0a),
        .i_q0b          (s_q0b),
        .i_q1a          (s_q1a),
        .i_q1b          (s_q1b)
    );

    sdcs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_store (
        .i_clk     (i_clk),
        .i_we      (s_ram_ctl.we0),
        .i_waddr   (s_waddr),
        .i_wdata   (s_wdata),
        .i_raddr_a (s_raddr_a),
        .i_raddr_b (s_raddr_b),
        .o_rdata_a (s_q0a),
        .o_rdata_b (s_q0b)
    );

    sdcs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_merge_buffer (
        .i_clk     (i_clk),
        .i_we      (s_ram_ctl.we1),
        .i_waddr   (s_waddr),
        .i_wdata   (s_wdata),
        .i_raddr_a (s_raddr_a),
        .i_raddr_b (s_raddr_b),
        .o_rdata_a (s_q1a),
        .o_rdata_b (s_q1b)
    );

endmodule

// ===== design/sdcs_checker.sv =====
module sdcs_checker #(
    parameter int COUNT_BITS = 16,
    parameter int TAG_BITS   = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_last,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [COUNT_BITS-1:0] o_sorted_count,
    input logic [TAG_BITS-1:0]   o_sorted_tag,
    input logic                  o_final_res,
    input logic                  o_dropped
);

    logic                  r_in_run;
    logic [COUNT_BITS-1:0] r_prev_cnt;
    logic                  r_prev_drop;
    logic                  s_out_xfer;

    assign s_out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (s_out_xfer) begin
            r_in_run <= !o_final_res;
        end
        if (s_out_xfer) begin
            r_prev_cnt  <= o_sorted_count;
            r_prev_drop <= o_dropped;
        end
    end

    // A stalled result holds until it is transferred.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_count)
            && $stable(o_sorted_tag) && $stable(o_final_res) && $stable(o_dropped))
        else $error("stalled result changed");

    // After the closing input transfer the block takes no more input while it sorts.
    a_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("input accepted after the set closed");

    // Within one run the counts never rise.
    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_xfer && r_in_run |-> o_sorted_count <= r_prev_cnt)
        else $error("results not in descending order");

    // The drop flag is the same on every result of a run.
    a_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_xfer && r_in_run |-> o_dropped == r_prev_drop)
        else $error("drop flag changed within a run");

endmodule

bind stable_descending_count_sort_top sdcs_checker #(
    .COUNT_BITS (COUNT_BITS),
    .TAG_BITS   (TAG_BITS)
) u_sdcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_count (o_sorted_count),
    .o_sorted_tag   (o_sorted_tag),
    .o_final_res    (o_final_res),
    .o_dropped      (o_dropped)
);

// ===== bench/stable_descending_count_sort_top_test.sv =====
module stable_descending_count_sort_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 64;
    localparam int CNT_W      = 16;
    localparam int TAG_W      = 10;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 100;

    typedef enum {FILL_RANDOM, FILL_TIES, FILL_RISING, FILL_EXTREME} t_fill;

    typedef struct {
        bit [CNT_W-1:0] count;
        bit [TAG_W-1:0] tag;
        bit             last;
        bit             hold;
    } t_word_item;

    typedef struct {
        bit [CNT_W-1:0] count;
        bit [TAG_W-1:0] tag;
        bit             final_res;
        bit             dropped;
    } t_ranked_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [CNT_W-1:0] i_entry_count = '0;
    logic [TAG_W-1:0] i_entry_tag = '0;
    logic             i_last = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [CNT_W-1:0] o_sorted_count;
    logic [TAG_W-1:0] o_sorted_tag;
    logic             o_final_res;
    logic             o_dropped;

    t_word_item   word_feed[$];
    t_ranked_word ranking_q[$];

    bit [CNT_W-1:0] held_count[CAPACITY];
    bit [TAG_W-1:0] held_tag[CAPACITY];
    int             held_n = 0;
    bit             held_overflow = 1'b0;

    int  mismatches = 0;
    int  results_checked = 0;
    int  words_sent = 0;
    int  sets_sorted = 0;
    int  overflow_sets = 0;
    int  full_sets = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    stable_descending_count_sort_top #(
        .MAX_ENTRIES (CAPACITY),
        .COUNT_BITS  (CNT_W),
        .TAG_BITS    (TAG_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_entry_count  (i_entry_count),
        .i_entry_tag    (i_entry_tag),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_count (o_sorted_count),
        .o_sorted_tag   (o_sorted_tag),
        .o_final_res    (o_final_res),
        .o_dropped      (o_dropped)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = int'($urandom_range(99));
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 40));
    endfunction

    // Files one word into the set and, when it closes the set, queues the ranking
    // the block must produce: descending count, equal counts in load order.
    task automatic file_entry(input t_word_item w);
        bit [CNT_W-1:0] cnt[CAPACITY];
        bit [TAG_W-1:0] tg[CAPACITY];
        bit [CNT_W-1:0] kc;
        bit [TAG_W-1:0] kt;
        t_ranked_word   r;
        int             j;
        if (held_n < CAPACITY) begin
            held_count[held_n] = w.count;
            held_tag[held_n] = w.tag;
            held_n++;
        end else begin
            held_overflow = 1'b1;
        end
        if (w.last) begin
            for (int i = 0; i < held_n; i++) begin
                cnt[i] = held_count[i];
                tg[i] = held_tag[i];
            end
            for (int i = 1; i < held_n; i++) begin
                kc = cnt[i];
                kt = tg[i];
                j = i;
                while (j > 0 && cnt[j-1] < kc) begin
                    cnt[j] = cnt[j-1];
                    tg[j] = tg[j-1];
                    j--;
                end
                cnt[j] = kc;
                tg[j] = kt;
            end
            for (int i = 0; i < held_n; i++) begin
                r.count = cnt[i];
                r.tag = tg[i];
                r.final_res = (i == held_n - 1);
                r.dropped = held_overflow;
                ranking_q.push_back(r);
            end
            sets_sorted++;
            if (held_overflow) begin
                overflow_sets++;
            end
            if (held_n == CAPACITY) begin
                full_sets++;
            end
            held_n = 0;
            held_overflow = 1'b0;
        end
    endtask

    task automatic push_word(input bit [CNT_W-1:0] c, input bit [TAG_W-1:0] t,
                             input bit last, input bit hold);
        t_word_item w;
        w.count = c;
        w.tag = t;
        w.last = last;
        w.hold = hold;
        word_feed.push_back(w);
    endtask

    task automatic add_set(input int size, input t_fill fill, input bit hold);
        bit [CNT_W-1:0] c;
        for (int i = 0; i < size; i++) begin
            case (fill)
                FILL_TIES: begin
                    c = CNT_W'($urandom_range(3));
                end
                FILL_RISING: begin
                    c = CNT_W'(i * 97);
                end
                FILL_EXTREME: begin
                    c = $urandom_range(1) ? '1 : '0;
                end
                default: begin
                    c = CNT_W'($urandom);
                end
            endcase
            push_word(c, TAG_W'($urandom), i == size - 1, hold && i == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(149) == 0) begin
            calm <= !calm;
        end
    end

    always @(posedge i_clk) begin
        bit took;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                file_entry(word_feed.pop_front());
                words_sent++;
                send_gap = pick_gap();
            end
            if (!i_valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (word_feed.size() != 0 &&
                             !(word_feed[0].hold && ranking_q.size() != 0)) begin
                    i_valid <= 1'b1;
                    i_entry_count <= word_feed[0].count;
                    i_entry_tag <= word_feed[0].tag;
                    i_last <= word_feed[0].last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = ($urandom_range(2) == 0) ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        t_ranked_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (ranking_q.size() == 0) begin
                $error("unexpected result: sorted_count %0d sorted_tag %0d",
                       o_sorted_count, o_sorted_tag);
                mismatches++;
            end else begin
                want = ranking_q.pop_front();
                results_checked++;
                if (o_sorted_count !== want.count) begin
                    $error("sorted_count: expected %0d, got %0d", want.count, o_sorted_count);
                    mismatches++;
                end
                if (o_sorted_tag !== want.tag) begin
                    $error("sorted_tag: expected %0d, got %0d", want.tag, o_sorted_tag);
                    mismatches++;
                end
                if (o_final_res !== want.final_res) begin
                    $error("final_res: expected %0d, got %0d", want.final_res, o_final_res);
                    mismatches++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %0d, got %0d", want.dropped, o_dropped);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("stable_descending_count_sort_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        int    random_words;
        int    size;
        int    r;
        t_fill fill;

        push_word(16'hffff, 10'h3ff, 1'b1, 1'b0);
        push_word(16'h0000, 10'h000, 1'b0, 1'b0);
        push_word(16'h0000, 10'h001, 1'b0, 1'b0);
        push_word(16'h0000, 10'h002, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++) begin
            push_word(CNT_W'(i + 1), TAG_W'(10'h100 + i), i == 5, 1'b0);
        end
        push_word(16'd5, 10'h00a, 1'b0, 1'b1);
        push_word(16'd9, 10'h00b, 1'b0, 1'b0);
        push_word(16'd5, 10'h00c, 1'b0, 1'b0);
        push_word(16'd9, 10'h00d, 1'b0, 1'b0);
        push_word(16'hffff, 10'h00e, 1'b0, 1'b0);
        push_word(16'd0, 10'h00f, 1'b0, 1'b0);
        push_word(16'd9, 10'h2aa, 1'b0, 1'b0);
        push_word(16'd5, 10'h155, 1'b1, 1'b0);
        push_word(16'h8000, 10'h200, 1'b0, 1'b0);
        push_word(16'h7fff, 10'h1ff, 1'b0, 1'b0);
        push_word(16'h0001, 10'h3fe, 1'b0, 1'b0);
        push_word(16'hfffe, 10'h001, 1'b1, 1'b0);

        add_set(CAPACITY, FILL_RANDOM, 1'b1);
        add_set(CAPACITY + 3, FILL_TIES, 1'b0);
        random_words = 0;
        while (random_words < 50) begin
            r = int'($urandom_range(99));
            if (r < 4) begin
                size = int'($urandom_range(CAPACITY, CAPACITY + 2));
            end else if (r < 16) begin
                size = int'($urandom_range(13, 40));
            end else begin
                size = int'($urandom_range(1, 12));
            end
            r = int'($urandom_range(9));
            fill = (r < 5) ? FILL_RANDOM : (r < 8) ? FILL_TIES :
                   (r < 9) ? FILL_EXTREME : FILL_RISING;
            add_set(size, fill, $urandom_range(9) == 0);
            random_words += size;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (word_feed.size() != 0 || i_valid);
        while (ranking_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_WAIT) @(negedge i_clk);

        $display("Sent %0d words in %0d sets, %0d of them full and %0d with words discarded.",
                 words_sent, sets_sorted, full_sets, overflow_sets);
        $display("Checked %0d sorted results with %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("stable_descending_count_sort_top_test: PASS");
        end else begin
            $display("stable_descending_count_sort_top_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== stable_descending_count_sort_top.f =====
design/sdcs_pkg.sv
design/sdcs_ram.sv
design/sdcs_ctrl.sv
design/stable_descending_count_sort_top.sv
design/sdcs_checker.sv
bench/stable_descending_count_sort_top_test.sv
